>>> src/triangle_area_3d_macros.svh
// Assertion macros for the triangle area block.
// Expects clk and rst_n in the scope of each use.
`ifndef TRIANGLE_AREA_3D_MACROS_SVH
`define TRIANGLE_AREA_3D_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define TRI_AREA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds a fixed number of cycles after ante
`define TRI_AREA_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## dly (cons)) \
        else $error(msg);

`endif

>>> src/tri_area_pkg.sv
// Shared constants and types for the triangle area block.
// No dependencies.
package tri_area_pkg;

    // Components of a 3D vector
    localparam int AXIS_N = 3;

    // Width of the area result, 25 fractional bits
    localparam int AREA_W = 51;

    typedef logic [AREA_W-1:0] area_t;

endpackage

>>> src/tri_area_cross.sv
// Edge vectors, cross product and per-axis magnitude, three register stages.
// Depends on tri_area_pkg.
module tri_area_cross
    import tri_area_pkg::*;
#(
    parameter int COORD_BITS = 24
)(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [AXIS_N-1:0][COORD_BITS-1:0]     p0,
    input  logic [AXIS_N-1:0][COORD_BITS-1:0]     p1,
    input  logic [AXIS_N-1:0][COORD_BITS-1:0]     p2,
    output logic                                  out_valid,
    output logic [AXIS_N-1:0][2*COORD_BITS:0]     mag
);

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * COORD_BITS + 2;
    localparam int CROSS_W = 2 * COORD_BITS + 3;
    localparam int MAG_W   = 2 * COORD_BITS + 1;

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] a_reg   [AXIS_N];
    logic signed [DIFF_W-1:0] a_next  [AXIS_N];
    logic signed [DIFF_W-1:0] b_reg   [AXIS_N];
    logic signed [DIFF_W-1:0] b_next  [AXIS_N];
    logic signed [PROD_W-1:0] pos_reg [AXIS_N];
    logic signed [PROD_W-1:0] pos_next[AXIS_N];
    logic signed [PROD_W-1:0] neg_reg [AXIS_N];
    logic signed [PROD_W-1:0] neg_next[AXIS_N];
    logic [MAG_W-1:0]         mag_reg [AXIS_N];
    logic [MAG_W-1:0]         mag_next[AXIS_N];

    for (genvar i = 0; i < AXIS_N; i++)
    begin : g_axis
        localparam int J = (i + 1) % AXIS_N;
        localparam int K = (i + 2) % AXIS_N;

        logic signed [CROSS_W-1:0] cr;

        // Form the edge vectors from the first corner
        assign a_next[i] = DIFF_W'($signed(p1[i])) - DIFF_W'($signed(p0[i]));
        assign b_next[i] = DIFF_W'($signed(p2[i])) - DIFF_W'($signed(p0[i]));

        // Two partial products of this cross product component
        assign pos_next[i] = PROD_W'(a_reg[J]) * PROD_W'(b_reg[K]);
        assign neg_next[i] = PROD_W'(a_reg[K]) * PROD_W'(b_reg[J]);

        // Subtract and drop the sign; the square needs only the magnitude
        assign cr          = CROSS_W'(pos_reg[i]) - CROSS_W'(neg_reg[i]);
        assign mag_next[i] = cr[CROSS_W-1] ? MAG_W'(-cr) : MAG_W'(cr);

        assign mag[i] = mag_reg[i];
    end

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance the data stages
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AXIS_N; i++)
        begin
            a_reg[i]   <= a_next[i];
            b_reg[i]   <= b_next[i];
            pos_reg[i] <= pos_next[i];
            neg_reg[i] <= neg_next[i];
            mag_reg[i] <= mag_next[i];
        end
    end

    assign out_valid = v3_reg;

endmodule

>>> src/tri_area_sqsum.sv
// Squared length of the cross product: split squares, then two sums.
// Depends on tri_area_pkg.
module tri_area_sqsum
    import tri_area_pkg::*;
#(
    parameter int COORD_BITS = 24
)(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [AXIS_N-1:0][2*COORD_BITS:0]     mag,
    output logic                                  out_valid,
    output logic [4*COORD_BITS+3:0]               sum
);

    localparam int MAG_W = 2 * COORD_BITS + 1;
    localparam int LO_W  = COORD_BITS + 1;
    localparam int HI_W  = MAG_W - LO_W;
    localparam int SQ1_W = 2 * MAG_W;
    localparam int SQ_W  = 4 * COORD_BITS + 4;

    logic                   v1_reg, v2_reg, v3_reg;
    logic [2*HI_W-1:0]      hh_reg  [AXIS_N];
    logic [2*HI_W-1:0]      hh_next [AXIS_N];
    logic [HI_W+LO_W-1:0]   hl_reg  [AXIS_N];
    logic [HI_W+LO_W-1:0]   hl_next [AXIS_N];
    logic [2*LO_W-1:0]      ll_reg  [AXIS_N];
    logic [2*LO_W-1:0]      ll_next [AXIS_N];
    logic [SQ1_W-1:0]       sq_reg  [AXIS_N];
    logic [SQ1_W-1:0]       sq_next [AXIS_N];
    logic [SQ_W-1:0]        sum_reg;
    logic [SQ_W-1:0]        sum_next;

    for (genvar i = 0; i < AXIS_N; i++)
    begin : g_axis
        logic [HI_W-1:0] hi;
        logic [LO_W-1:0] lo;

        // Split the magnitude so each multiplier stays narrow
        assign hi = mag[i][MAG_W-1:LO_W];
        assign lo = mag[i][LO_W-1:0];

        assign hh_next[i] = (2*HI_W)'(hi) * (2*HI_W)'(hi);
        assign hl_next[i] = (HI_W+LO_W)'(hi) * (HI_W+LO_W)'(lo);
        assign ll_next[i] = (2*LO_W)'(lo) * (2*LO_W)'(lo);

        // Recombine: hi^2 * 2^(2L) + 2 * hi * lo * 2^L + lo^2
        assign sq_next[i] = (SQ1_W'(hh_reg[i]) << (2 * LO_W))
                          + (SQ1_W'(hl_reg[i]) << (LO_W + 1))
                          + SQ1_W'(ll_reg[i]);
    end

    // Sum the three squares
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < AXIS_N; i++)
        begin
            sum_next = sum_next + SQ_W'(sq_reg[i]);
        end
    end

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance the data stages
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AXIS_N; i++)
        begin
            hh_reg[i] <= hh_next[i];
            hl_reg[i] <= hl_next[i];
            ll_reg[i] <= ll_next[i];
            sq_reg[i] <= sq_next[i];
        end
        sum_reg <= sum_next;
    end

    assign out_valid = v3_reg;
    assign sum       = sum_reg;

endmodule

>>> src/tri_area_cell.sv
// One cell of the square root chain: settles one root bit per request.
// No dependencies.
module tri_area_cell #(
    parameter int ROOT_W = 50
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_rad,
    input  logic [ROOT_W:0]       in_rem,
    input  logic [ROOT_W-1:0]     in_root,
    output logic                  out_valid,
    output logic [2*ROOT_W-1:0]   out_rad,
    output logic [ROOT_W:0]       out_rem,
    output logic [ROOT_W-1:0]     out_root
);

    localparam int CUR_W = ROOT_W + 3;

    logic                  valid_reg;
    logic [2*ROOT_W-1:0]   rad_reg, rad_next;
    logic [ROOT_W:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [CUR_W-1:0]      cur, trial, diff;
    logic                  take;

    // Bring down the next two radicand bits and try root*4 + 1
    always_comb
    begin
        cur       = {in_rem, in_rad[2*ROOT_W-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        diff      = cur - trial;
        take      = (cur >= trial);
        rem_next  = take ? diff[ROOT_W:0] : cur[ROOT_W:0];
        root_next = {in_root[ROOT_W-2:0], take};
        rad_next  = {in_rad[2*ROOT_W-3:0], 2'b00};
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Hand the partial result to the next cell
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

>>> src/triangle_area_3d.sv
// Top level of the 3D triangle area block: cross product, squared length, root chain.
// Depends on tri_area_pkg, tri_area_cross, tri_area_sqsum, tri_area_cell and the macros.
//
//   Channel   Handshake           Payload
//   request   start / busy        p0_x .. p2_z, COORD_BITS each, signed Q12.12
//   result    done (one cycle)    area, 51 bits, 25 fractional bits
//
// A request is taken every cycle; busy stays low.
// Its area passes six stages of arithmetic, one cell per root bit (2*COORD_BITS + 2)
// and one output stage.
// Reset clears every valid flag; requests in flight are dropped.
// The receiver cannot stall, so done and area are never held.
`include "triangle_area_3d_macros.svh"

module triangle_area_3d
    import tri_area_pkg::*;
#(
    parameter int COORD_BITS = 24
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  p0_x,
    input  logic signed [COORD_BITS-1:0]  p0_y,
    input  logic signed [COORD_BITS-1:0]  p0_z,
    input  logic signed [COORD_BITS-1:0]  p1_x,
    input  logic signed [COORD_BITS-1:0]  p1_y,
    input  logic signed [COORD_BITS-1:0]  p1_z,
    input  logic signed [COORD_BITS-1:0]  p2_x,
    input  logic signed [COORD_BITS-1:0]  p2_y,
    input  logic signed [COORD_BITS-1:0]  p2_z,
    output logic                          done,
    output logic [AREA_W-1:0]             area
);

    localparam int MAG_W   = 2 * COORD_BITS + 1;
    localparam int ROOT_W  = 2 * COORD_BITS + 2;
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int LATENCY = ROOT_W + 7;

    logic                              accept;
    logic [AXIS_N-1:0][COORD_BITS-1:0] c0, c1, c2;
    logic                              mag_valid;
    logic [AXIS_N-1:0][MAG_W-1:0]      mag;
    logic                              sq_valid;
    logic [SQ_W-1:0]                   sq_sum;

    logic                  chain_valid[ROOT_W+1];
    logic [SQ_W-1:0]       chain_rad  [ROOT_W+1];
    logic [ROOT_W:0]       chain_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]     chain_root [ROOT_W+1];

    logic [ROOT_W-1:0]     root_fin;
    logic [ROOT_W:0]       root_dbl;
    logic [ROOT_W:0]       rem_fin;
    logic                  coincident;
    area_t                 area_reg, area_next;
    logic                  done_reg;

    // Never stall the request side
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Pack the corners, x in the lowest slot
    assign c0 = {p0_z, p0_y, p0_x};
    assign c1 = {p1_z, p1_y, p1_x};
    assign c2 = {p2_z, p2_y, p2_x};

    tri_area_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .p0        (c0),
        .p1        (c1),
        .p2        (c2),
        .out_valid (mag_valid),
        .mag       (mag)
    );

    tri_area_sqsum #(
        .COORD_BITS (COORD_BITS)
    ) u_sqsum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mag_valid),
        .mag       (mag),
        .out_valid (sq_valid),
        .sum       (sq_sum)
    );

    // Seed the root chain with the squared length
    assign chain_valid[0] = sq_valid;
    assign chain_rad[0]   = sq_sum;
    assign chain_rem[0]   = '0;
    assign chain_root[0]  = '0;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        tri_area_cell #(
            .ROOT_W (ROOT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_rad    (chain_rad[i]),
            .in_rem    (chain_rem[i]),
            .in_root   (chain_root[i]),
            .out_valid (chain_valid[i+1]),
            .out_rad   (chain_rad[i+1]),
            .out_rem   (chain_rem[i+1]),
            .out_root  (chain_root[i+1])
        );
    end

    assign root_fin = chain_root[ROOT_W];
    assign root_dbl = {root_fin, 1'b0};
    assign rem_fin  = chain_rem[ROOT_W];

    // Clamp the root to the area width
    if (ROOT_W > AREA_W)
    begin : g_sat
        assign area_next = (|root_fin[ROOT_W-1:AREA_W]) ? '1 : root_fin[AREA_W-1:0];
    end
    else
    begin : g_nosat
        assign area_next = AREA_W'(root_fin);
    end

    // Hold the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[ROOT_W];
        end
    end

    // Register the area
    always_ff @(posedge clk)
    begin
        area_reg <= area_next;
    end

    assign done = done_reg;
    assign area = area_reg;

    // Flag a request whose three corners are equal
    assign coincident = accept && (c1 == c0) && (c2 == c0);

    // Each request gives its result a fixed number of cycles later
    `TRI_AREA_ASSERT_DELAY(a_latency, accept, LATENCY, done, "result strobe missing after request")

    // The final remainder never exceeds twice the root
    `TRI_AREA_ASSERT_IMPLY(a_rem_bound, chain_valid[ROOT_W], rem_fin <= root_dbl, "remainder out of range")

    // Three equal corners give zero area
    `TRI_AREA_ASSERT_DELAY(a_degenerate, coincident, LATENCY, area == '0, "nonzero degenerate area")

endmodule

>>> dv/tri_area_checker.sv
// Result checker for the 3D triangle area block: predicts the area of each accepted
// request and compares it with the area reported on the result strobe.
// Depends on tri_area_pkg for the area width and type.
module tri_area_checker
    import tri_area_pkg::*;
#(
    parameter int COORD_BITS = 24
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [COORD_BITS-1:0]  p0_x,
    input  logic signed [COORD_BITS-1:0]  p0_y,
    input  logic signed [COORD_BITS-1:0]  p0_z,
    input  logic signed [COORD_BITS-1:0]  p1_x,
    input  logic signed [COORD_BITS-1:0]  p1_y,
    input  logic signed [COORD_BITS-1:0]  p1_z,
    input  logic signed [COORD_BITS-1:0]  p2_x,
    input  logic signed [COORD_BITS-1:0]  p2_y,
    input  logic signed [COORD_BITS-1:0]  p2_z,
    input  logic                          done,
    input  logic [AREA_W-1:0]             area,
    output int                            pending,
    output int                            mismatches
);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef coord_t corner_set_t [9];

    localparam logic [127:0] AREA_MAX = {77'd0, {AREA_W{1'b1}}};

    area_t areas_in_flight [$];
    int    error_total = 0;

    // Half the length of (P1 - P0) x (P2 - P0), as floor of the root of |c|^2
    function automatic area_t cross_area(input corner_set_t v);
        longint       pt [9];
        longint       edge_a [3];
        longint       edge_b [3];
        longint       cross_v [3];
        longint       cabs;
        logic [127:0] len_sq;
        logic [127:0] root;
        logic [127:0] trial;
        logic [127:0] mag;
        len_sq = '0;
        root   = '0;
        for (int i = 0; i < 9; i++)
            pt[i] = v[i];
        for (int i = 0; i < AXIS_N; i++)
        begin
            edge_a[i] = pt[3 + i] - pt[i];
            edge_b[i] = pt[6 + i] - pt[i];
        end
        cross_v[0] = edge_a[1] * edge_b[2] - edge_a[2] * edge_b[1];
        cross_v[1] = edge_a[2] * edge_b[0] - edge_a[0] * edge_b[2];
        cross_v[2] = edge_a[0] * edge_b[1] - edge_a[1] * edge_b[0];
        for (int i = 0; i < AXIS_N; i++)
        begin
            cabs   = (cross_v[i] < 0) ? -cross_v[i] : cross_v[i];
            mag    = 128'(cabs);
            len_sq = len_sq + mag * mag;
        end
        // Settle the root one bit at a time, high to low
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= len_sq)
                root = trial;
        end
        if (root > AREA_MAX)
            root = AREA_MAX;
        return area_t'(root);
    endfunction

    // Queue each accepted request's area, retire each strobed result
    always @(posedge clk)
    begin : watch
        corner_set_t req;
        area_t       want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                req = '{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z};
                areas_in_flight.push_back(cross_area(req));
            end
            if (done)
            begin
                if (areas_in_flight.size() == 0)
                begin
                    $error("area result %0d with no request outstanding", area);
                    error_total++;
                end
                else
                begin
                    want = areas_in_flight.pop_front();
                    if (area !== want)
                    begin
                        $error("area mismatch: expected %0d, actual %0d", want, area);
                        error_total++;
                    end
                end
            end
        end
        pending    <= areas_in_flight.size();
        mismatches <= error_total;
    end

endmodule

>>> dv/tb_triangle_area_3d.sv
// Testbench top for the 3D triangle area block: drives directed and random triangles,
// idles the request side at random and gives the verdict.
// Depends on tri_area_pkg, triangle_area_3d and tri_area_checker.
module tb_triangle_area_3d
    import tri_area_pkg::*;
();

    localparam int COORD_BITS   = 24;
    localparam int RANDOM_ITEMS = 1950;
    localparam int TAIL_CYCLES  = 2 * COORD_BITS + 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef coord_t triangle_t [9];

    typedef enum int {
        SHAPE_FULL,
        SHAPE_SMALL,
        SHAPE_FLAT,
        SHAPE_DEGENERATE,
        SHAPE_EDGE
    } shape_t;

    localparam coord_t C_MAX   = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t C_MIN   = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam coord_t ZERO    = '0;
    localparam coord_t LSB     = coord_t'(1);
    localparam coord_t NEG_LSB = coord_t'(-1);
    localparam coord_t ONE     = coord_t'(4096);
    localparam coord_t NEG_ONE = coord_t'(-4096);

    logic   clk;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    coord_t p0_x = '0, p0_y = '0, p0_z = '0;
    coord_t p1_x = '0, p1_y = '0, p1_z = '0;
    coord_t p2_x = '0, p2_y = '0, p2_z = '0;
    logic   done;
    area_t  area;
    int     pending;
    int     mismatches;
    int     cycles = 0;

    triangle_area_3d #(.COORD_BITS(COORD_BITS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
        .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
        .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
        .done(done), .area(area)
    );

    tri_area_checker #(.COORD_BITS(COORD_BITS)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
        .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
        .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
        .done(done), .area(area),
        .pending(pending), .mismatches(mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("triangle_area_3d test failed");
            $finish;
        end
    end

    function automatic int rand_span(input int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    function automatic coord_t edge_value();
        case ($urandom_range(6))
            0: return C_MIN;
            1: return C_MAX;
            2: return ZERO;
            3: return LSB;
            4: return NEG_LSB;
            5: return ONE;
            default: return NEG_ONE;
        endcase
    endfunction

    // Build one triangle of the given shape
    function automatic triangle_t random_triangle(input shape_t shape);
        triangle_t t;
        int        dir [3];
        int        k1;
        int        k2;
        int        base;
        case (shape)
            SHAPE_FULL:
                for (int i = 0; i < 9; i++)
                    t[i] = coord_t'($urandom);
            SHAPE_SMALL:
                for (int i = 0; i < 9; i++)
                    t[i] = coord_t'(rand_span(4096));
            SHAPE_FLAT:
            begin
                // Collinear corners, sometimes nudged off the line by one step
                k1 = rand_span(8);
                k2 = rand_span(8);
                for (int i = 0; i < 3; i++)
                begin
                    base     = rand_span(1 << 20);
                    dir[i]   = rand_span(1 << 10);
                    t[i]     = coord_t'(base);
                    t[3 + i] = coord_t'(base + k1 * dir[i]);
                    t[6 + i] = coord_t'(base + k2 * dir[i]);
                end
                if ($urandom_range(1))
                    t[3 + $urandom_range(5)] += coord_t'(rand_span(1));
            end
            SHAPE_DEGENERATE:
            begin
                for (int i = 0; i < 9; i++)
                    t[i] = coord_t'($urandom);
                // Make two or three corners coincide
                case ($urandom_range(3))
                    0: for (int i = 0; i < 3; i++) t[3 + i] = t[i];
                    1: for (int i = 0; i < 3; i++) t[6 + i] = t[i];
                    2: for (int i = 0; i < 3; i++) t[6 + i] = t[3 + i];
                    default:
                        for (int i = 0; i < 3; i++)
                        begin
                            t[3 + i] = t[i];
                            t[6 + i] = t[i];
                        end
                endcase
            end
            default:
                for (int i = 0; i < 9; i++)
                    t[i] = edge_value();
        endcase
        return t;
    endfunction

    // Present one request and hold it until accepted
    task automatic send_triangle(input triangle_t t);
        p0_x  <= t[0];
        p0_y  <= t[1];
        p0_z  <= t[2];
        p1_x  <= t[3];
        p1_y  <= t[4];
        p1_z  <= t[5];
        p2_x  <= t[6];
        p2_y  <= t[7];
        p2_z  <= t[8];
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drop start and hold until every outstanding area has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin : stimulus
        int     pick;
        shape_t shape;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, axis planes, unit and minimal areas, degenerate cases
        send_triangle('{ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO});
        send_triangle('{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX});
        send_triangle('{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN});
        send_triangle('{C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN});
        send_triangle('{C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX});
        send_triangle('{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN});
        send_triangle('{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX});
        send_triangle('{C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN});
        send_triangle('{ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, ZERO});
        send_triangle('{ZERO, ZERO, ZERO, NEG_ONE, ZERO, ZERO, ZERO, ZERO, NEG_ONE});
        send_triangle('{ZERO, ZERO, ZERO, ONE, ONE, ONE,
                        coord_t'(8192), coord_t'(8192), coord_t'(8192)});
        send_triangle('{C_MIN, C_MIN, C_MIN, ZERO, ZERO, ZERO, C_MAX, C_MAX, C_MAX});
        send_triangle('{C_MAX, C_MIN, NEG_LSB, C_MAX, C_MIN, NEG_LSB, C_MAX, C_MIN, NEG_LSB});
        send_triangle('{C_MIN, ONE, C_MAX, C_MIN, ONE, C_MAX, NEG_ONE, ZERO, C_MIN});
        send_triangle('{LSB, C_MAX, ZERO, C_MIN, NEG_LSB, ONE, LSB, C_MAX, ZERO});
        send_triangle('{ZERO, ZERO, ZERO, LSB, ZERO, ZERO, ZERO, LSB, ZERO});
        send_triangle('{ZERO, ZERO, ZERO, C_MAX, C_MAX, C_MAX,
                        C_MAX, C_MAX, coord_t'(C_MAX - 1)});
        send_triangle('{C_MAX, ZERO, C_MIN, ZERO, C_MIN, C_MAX, C_MIN, C_MAX, ZERO});
        drain_results();

        // Random: mostly general triangles, plus flat, coincident and extreme ones
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                shape = SHAPE_FULL;
            else if (pick < 60)
                shape = SHAPE_SMALL;
            else if (pick < 75)
                shape = SHAPE_FLAT;
            else if (pick < 85)
                shape = SHAPE_DEGENERATE;
            else
                shape = SHAPE_EDGE;
            send_triangle(random_triangle(shape));
            if (n == 700 || n == 1500)
                drain_results();
            else if ((n < 900 || n >= 1300) && $urandom_range(99) < 12)
                idle_for($urandom_range(1, 6));
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("triangle_area_3d test passed");
        else
            $display("triangle_area_3d test failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/tri_area_pkg.sv
src/tri_area_cross.sv
src/tri_area_sqsum.sv
src/tri_area_cell.sv
src/triangle_area_3d.sv
dv/tri_area_checker.sv
dv/tb_triangle_area_3d.sv
